FILE: rtl/dpc_pkg.sv
// Package for the DNS packet classifier: widths, command and verdict codes,
// and the structs passed between the parser, the match cells and the top level.
// No dependencies.
`default_nettype none
package dpc_pkg;

	localparam int QUEUE_COUNT = 64;
	localparam int PORT_ENTRIES = 64;
	localparam int BLACKLIST_ENTRIES = 64;
	localparam int DNS_HEADER_BYTES = 12;

	localparam int ETH_HDR_LEN = 14;
	localparam int IPV4_MIN_LEN = 20;
	localparam int IPV6_HDR_LEN = 40;
	localparam int UDP_HDR_LEN = 8;
	localparam logic [15:0] KIND_IPV4 = 16'h0800;
	localparam logic [15:0] KIND_IPV6 = 16'h86DD;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	localparam int NUM_COUNTERS = 5;

	// Match cells per registered group, and the number of groups in the chain.
	localparam int CHAIN_GROUP = 8;
	localparam int CHAIN_STAGES = PORT_ENTRIES / CHAIN_GROUP;

	typedef enum logic [2:0] {
		CMD_BYTE = 3'd0,
		CMD_PORT = 3'd1,
		CMD_PREFIX = 3'd2,
		CMD_QUEUE = 3'd3,
		CMD_READ = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		VERDICT_PASS = 2'd0,
		VERDICT_DROP = 2'd1,
		VERDICT_REDIRECT = 2'd2
	} verdict_t;

	typedef enum logic [1:0] {
		IPK_NONE = 2'd0,
		IPK_V4 = 2'd1,
		IPK_V6 = 2'd2,
		IPK_BAD = 2'd3
	} ip_kind_t;

	localparam logic [2:0] CNT_TOTAL = 3'd0;
	localparam logic [2:0] CNT_DNS = 3'd1;
	localparam logic [2:0] CNT_REDIR = 3'd2;
	localparam logic [2:0] CNT_BLOCK = 3'd3;
	localparam logic [2:0] CNT_PASS = 3'd4;

	// Headers of a finished packet, handed from the parser to the match chain.
	typedef struct packed {
		logic [16:0] len;
		logic [15:0] ether_kind;
		ip_kind_t ip_kind;
		logic [7:0] l4_start;
		logic [7:0] ip_proto;
		logic [31:0] src_addr;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [5:0] queue;
	} pkt_hdr_t;

	// Partial match results carried along the chain of cells.
	typedef struct packed {
		logic src_hit;
		logic dst_hit;
		logic blocked;
	} match_t;

	// A table write broadcast to every cell.
	typedef struct packed {
		logic port_we;
		logic prefix_we;
		logic [5:0] index;
		logic entry_valid;
		logic [15:0] port_value;
		logic [31:0] prefix_addr;
		logic [5:0] prefix_len;
	} tbl_wr_t;

endpackage
`default_nettype wire

FILE: rtl/dpc_parser.sv
// Byte-serial header parser for the DNS packet classifier.
// Depends on dpc_pkg; emits one header record per finished packet.
`default_nettype none
module dpc_parser (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic byte_en,
	input wire logic [7:0] pkt_byte,
	input wire logic last_byte,
	input wire logic [5:0] rx_queue,
	output logic hdr_valid,
	output dpc_pkg::pkt_hdr_t hdr
);
	import dpc_pkg::*;

	logic [15:0] offset_q;
	logic [15:0] ether_kind_q;
	ip_kind_t ip_kind_q;
	logic [7:0] l4_start_q;
	logic [7:0] ip_proto_q;
	logic [31:0] src_addr_q;
	logic [15:0] sport_q;
	logic [15:0] dport_q;

	logic [15:0] ek_n;
	ip_kind_t ik_n;
	logic [7:0] l4_n;
	logic [7:0] proto_n;
	logic [31:0] sa_n;
	logic [15:0] sp_n;
	logic [15:0] dp_n;
	logic [15:0] off_n;
	logic [16:0] rel;

	// Next parse state for the byte at the current offset.
	always_comb begin
		ek_n = ether_kind_q;
		ik_n = ip_kind_q;
		l4_n = l4_start_q;
		proto_n = ip_proto_q;
		sa_n = src_addr_q;
		sp_n = sport_q;
		dp_n = dport_q;
		rel = {1'b0, offset_q} - {9'd0, l4_start_q};
		if (offset_q == 16'd12) begin
			ek_n = {pkt_byte, ether_kind_q[7:0]};
		end else if (offset_q == 16'd13) begin
			ek_n = {ether_kind_q[15:8], pkt_byte};
		end else if (offset_q == 16'(ETH_HDR_LEN)) begin
			if (ether_kind_q == KIND_IPV4) begin
				if (pkt_byte[3:0] < 4'd5) begin
					ik_n = IPK_BAD;
				end else begin
					ik_n = IPK_V4;
					l4_n = 8'(ETH_HDR_LEN) + {2'b00, pkt_byte[3:0], 2'b00};
				end
			end else if (ether_kind_q == KIND_IPV6) begin
				ik_n = IPK_V6;
				l4_n = 8'(ETH_HDR_LEN + IPV6_HDR_LEN);
			end
		end
		// Later checks see the kind as it stood before this byte.
		if (ip_kind_q == IPK_V4 && offset_q == 16'(ETH_HDR_LEN + 9)) begin
			proto_n = pkt_byte;
		end
		if (ip_kind_q == IPK_V6 && offset_q == 16'(ETH_HDR_LEN + 6)) begin
			proto_n = pkt_byte;
		end
		if (ip_kind_q == IPK_V4 && offset_q >= 16'(ETH_HDR_LEN + 12)
				&& offset_q < 16'(ETH_HDR_LEN + 16)) begin
			sa_n = {src_addr_q[23:0], pkt_byte};
		end
		if ((ip_kind_q == IPK_V4 || ip_kind_q == IPK_V6) && !rel[16]
				&& rel[15:0] < 16'd4) begin
			if (rel[1] == 1'b0) begin
				sp_n = {sport_q[7:0], pkt_byte};
			end else begin
				dp_n = {dport_q[7:0], pkt_byte};
			end
		end
		off_n = (offset_q == 16'hFFFF) ? offset_q : offset_q + 16'd1;
	end

	// Parse state; cleared after the final byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			ether_kind_q <= '0;
			ip_kind_q <= IPK_NONE;
			l4_start_q <= '0;
			ip_proto_q <= '0;
			src_addr_q <= '0;
			sport_q <= '0;
			dport_q <= '0;
		end else if (byte_en) begin
			if (last_byte) begin
				offset_q <= '0;
				ether_kind_q <= '0;
				ip_kind_q <= IPK_NONE;
				l4_start_q <= '0;
				ip_proto_q <= '0;
				src_addr_q <= '0;
				sport_q <= '0;
				dport_q <= '0;
			end else begin
				offset_q <= off_n;
				ether_kind_q <= ek_n;
				ip_kind_q <= ik_n;
				l4_start_q <= l4_n;
				ip_proto_q <= proto_n;
				src_addr_q <= sa_n;
				sport_q <= sp_n;
				dport_q <= dp_n;
			end
		end
	end

	// Header record of the packet that ends on this byte.
	always_comb begin
		hdr_valid = byte_en && last_byte;
		hdr.len = {1'b0, off_n} + {16'd0, off_n == 16'hFFFF};
		hdr.ether_kind = ek_n;
		hdr.ip_kind = ik_n;
		hdr.l4_start = l4_n;
		hdr.ip_proto = proto_n;
		hdr.src_addr = sa_n;
		hdr.sport = sp_n;
		hdr.dport = dp_n;
		hdr.queue = rx_queue;
	end

endmodule
`default_nettype wire

FILE: rtl/dpc_cell.sv
// One match cell: holds one port entry and one blacklist prefix and
// ORs its hits into the record passed to its neighbor. Depends on dpc_pkg.
`default_nettype none
module dpc_cell (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [5:0] cell_index,
	input wire dpc_pkg::tbl_wr_t wr,
	input wire logic [31:0] src_addr,
	input wire logic [15:0] sport,
	input wire logic [15:0] dport,
	input wire dpc_pkg::match_t match_in,
	output dpc_pkg::match_t match_out
);
	import dpc_pkg::*;

	logic port_valid_q;
	logic [15:0] port_q;
	logic prefix_valid_q;
	logic [5:0] len_q;
	logic [31:0] addr_q;
	logic [31:0] mask;

	// Table slot valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_valid_q <= 1'b0;
			prefix_valid_q <= 1'b0;
		end else begin
			if (wr.port_we && wr.index == cell_index) begin
				port_valid_q <= wr.entry_valid;
			end
			if (wr.prefix_we && wr.index == cell_index) begin
				prefix_valid_q <= wr.entry_valid;
			end
		end
	end

	// Slot contents; prefix length saturates at 32.
	always_ff @(posedge clk) begin
		if (wr.port_we && wr.index == cell_index) begin
			port_q <= wr.port_value;
		end
		if (wr.prefix_we && wr.index == cell_index) begin
			addr_q <= wr.prefix_addr;
			len_q <= (wr.prefix_len > 6'd32) ? 6'd32 : wr.prefix_len;
		end
	end

	// Compare and fold into the running match.
	always_comb begin
		mask = (len_q == 6'd0) ? 32'd0 : (32'hFFFF_FFFF << (6'd32 - len_q));
		match_out.src_hit = match_in.src_hit || (port_valid_q && port_q == sport);
		match_out.dst_hit = match_in.dst_hit || (port_valid_q && port_q == dport);
		match_out.blocked = match_in.blocked
			|| (prefix_valid_q && ((src_addr ^ addr_q) & mask) == 32'd0);
	end

endmodule
`default_nettype wire

FILE: rtl/dpc_chain.sv
// Row of match cells, registered every eight cells so a header record
// flows through the table group by group. Depends on dpc_pkg, dpc_cell.
`default_nettype none
module dpc_chain (
	input wire logic clk,
	input wire logic arst_n,
	input wire dpc_pkg::tbl_wr_t wr,
	input wire logic in_valid,
	input wire dpc_pkg::pkt_hdr_t in_hdr,
	output logic out_valid,
	output dpc_pkg::pkt_hdr_t out_hdr,
	output dpc_pkg::match_t out_match
);
	import dpc_pkg::*;

	localparam int GROUP = CHAIN_GROUP;
	localparam int NGROUPS = CHAIN_STAGES;

	logic [NGROUPS:0] valid_s;
	pkt_hdr_t hdr_s [NGROUPS+1];
	match_t match_s [NGROUPS+1];
	tbl_wr_t wr_s [NGROUPS];

	assign valid_s[0] = in_valid;
	assign hdr_s[0] = in_hdr;
	assign match_s[0] = '0;
	assign wr_s[0] = wr;

	for (genvar g = 0; g < NGROUPS; g++) begin : g_grp
		match_t link [GROUP+1];
		assign link[0] = match_s[g];
		for (genvar c = 0; c < GROUP; c++) begin : g_cell
			dpc_cell u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.cell_index(6'(g * GROUP + c)),
				.wr(wr_s[g]),
				.src_addr(hdr_s[g].src_addr),
				.sport(hdr_s[g].sport),
				.dport(hdr_s[g].dport),
				.match_in(link[c]),
				.match_out(link[c+1])
			);
		end
		// Stage register after each group of cells.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[g+1] <= 1'b0;
			end else begin
				valid_s[g+1] <= valid_s[g];
			end
		end
		always_ff @(posedge clk) begin
			hdr_s[g+1] <= hdr_s[g];
			match_s[g+1] <= link[GROUP];
		end
		// Table writes move one group per cycle, in step with the headers, so
		// every packet is matched against the tables as of its final byte.
		if (g < NGROUPS - 1) begin : g_wr
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					wr_s[g+1] <= '0;
				end else begin
					wr_s[g+1] <= wr_s[g];
				end
			end
		end
	end

	assign out_valid = valid_s[NGROUPS];
	assign out_hdr = hdr_s[NGROUPS];
	assign out_match = match_s[NGROUPS];

endmodule
`default_nettype wire

FILE: rtl/dns_packet_classifier.sv
// DNS packet classifier top level: parser, match chain, verdict, counters, output FIFO.
// Depends on dpc_pkg, dpc_parser, dpc_chain.
`default_nettype none
// Takes one transaction per cycle: a packet byte, a table write, or a counter
// read. On the final byte of a packet the parsed headers run through a chain of
// 64 match cells in eight registered groups before the verdict is formed; counter
// reads wait behind verdicts still in the chain so results keep their order.
// Table and queue writes follow the same pipeline, so each packet is judged with
// the tables as they stood at its final byte. Input stalls only when the output
// FIFO could not take the results already in flight, so with a free-running
// consumer one transaction is taken every cycle.
module dns_packet_classifier (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [2:0] command,
	input wire logic [7:0] pkt_byte,
	input wire logic last_byte,
	input wire logic [5:0] rx_queue,
	input wire logic [5:0] entry_index,
	input wire logic entry_valid,
	input wire logic [15:0] port_value,
	input wire logic [31:0] prefix_addr,
	input wire logic [5:0] prefix_len,
	input wire logic queue_enable,
	input wire logic [2:0] counter_select,
	output logic out_valid,
	input wire logic out_stall,
	output logic result_kind,
	output logic [1:0] verdict,
	output logic [5:0] out_queue,
	output logic is_dns,
	output logic [63:0] counter_value
);
	import dpc_pkg::*;

	localparam int LAT = CHAIN_STAGES;
	localparam int FDEPTH = 16;
	localparam int FAW = $clog2(FDEPTH);

	logic accept;
	logic byte_en;
	logic hdr_valid;
	pkt_hdr_t hdr;
	tbl_wr_t wr;
	logic ch_valid;
	pkt_hdr_t ch_hdr;
	match_t ch_match;

	assign accept = in_valid && !in_stall;
	assign byte_en = accept && cmd_t'(command) == CMD_BYTE;

	// Table write broadcast.
	always_comb begin
		wr.port_we = accept && cmd_t'(command) == CMD_PORT;
		wr.prefix_we = accept && cmd_t'(command) == CMD_PREFIX;
		wr.index = entry_index;
		wr.entry_valid = entry_valid;
		wr.port_value = port_value;
		wr.prefix_addr = prefix_addr;
		wr.prefix_len = prefix_len;
	end

	dpc_parser u_parser (
		.clk(clk), .arst_n(arst_n), .byte_en(byte_en), .pkt_byte(pkt_byte),
		.last_byte(last_byte), .rx_queue(rx_queue), .hdr_valid(hdr_valid), .hdr(hdr)
	);

	dpc_chain u_chain (
		.clk(clk), .arst_n(arst_n), .wr(wr), .in_valid(hdr_valid), .in_hdr(hdr),
		.out_valid(ch_valid), .out_hdr(ch_hdr), .out_match(ch_match)
	);

	// Counter reads and queue enable writes ride delay lines beside the chain
	// to keep order with the verdicts.
	logic [LAT:0] rd_v_s;
	logic [2:0] rd_sel_s [LAT+1];
	logic [LAT:0] qw_v_s;
	logic [6:0] qw_s [LAT+1];
	assign rd_v_s[0] = accept && cmd_t'(command) == CMD_READ && counter_select <= CNT_PASS;
	assign rd_sel_s[0] = counter_select;
	assign qw_v_s[0] = accept && cmd_t'(command) == CMD_QUEUE;
	assign qw_s[0] = {queue_enable, entry_index};
	for (genvar i = 0; i < LAT; i++) begin : g_rd
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rd_v_s[i+1] <= 1'b0;
				qw_v_s[i+1] <= 1'b0;
			end else begin
				rd_v_s[i+1] <= rd_v_s[i];
				qw_v_s[i+1] <= qw_v_s[i];
			end
		end
		always_ff @(posedge clk) begin
			rd_sel_s[i+1] <= rd_sel_s[i];
			qw_s[i+1] <= qw_s[i];
		end
	end

	// Queue enables.
	logic [QUEUE_COUNT-1:0] qen_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qen_q <= '0;
		end else if (qw_v_s[LAT]) begin
			qen_q[qw_s[LAT][5:0]] <= qw_s[LAT][6];
		end
	end

	// Verdict for the header leaving the chain.
	logic dns;
	verdict_t vd;
	logic [17:0] l4e;
	always_comb begin
		l4e = {10'd0, ch_hdr.l4_start} + 18'(UDP_HDR_LEN);
		dns = 1'b1;
		if (ch_hdr.len < 17'(ETH_HDR_LEN)) dns = 1'b0;
		if (ch_hdr.ether_kind != KIND_IPV4 && ch_hdr.ether_kind != KIND_IPV6) dns = 1'b0;
		if (ch_hdr.ether_kind == KIND_IPV4 && ch_hdr.len < 17'(ETH_HDR_LEN + IPV4_MIN_LEN))
			dns = 1'b0;
		if (ch_hdr.ether_kind == KIND_IPV6 && ch_hdr.len < 17'(ETH_HDR_LEN + IPV6_HDR_LEN))
			dns = 1'b0;
		if (ch_hdr.ip_kind != IPK_V4 && ch_hdr.ip_kind != IPK_V6) dns = 1'b0;
		if (ch_hdr.ip_proto != PROTO_UDP) dns = 1'b0;
		if ({1'b0, ch_hdr.len} < l4e) dns = 1'b0;
		if (!ch_match.src_hit && !ch_match.dst_hit) dns = 1'b0;
		if ({1'b0, ch_hdr.len} < l4e + 18'(DNS_HEADER_BYTES)) dns = 1'b0;
		if (!dns) begin
			vd = VERDICT_PASS;
		end else if (ch_hdr.ip_kind == IPK_V4 && ch_match.blocked) begin
			vd = VERDICT_DROP;
		end else if (qen_q[ch_hdr.queue]) begin
			vd = VERDICT_REDIRECT;
		end else begin
			vd = VERDICT_PASS;
		end
	end

	// Statistics counters.
	logic [63:0] cnt_q [NUM_COUNTERS];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COUNTERS; i++) cnt_q[i] <= '0;
		end else if (ch_valid) begin
			cnt_q[CNT_TOTAL] <= cnt_q[CNT_TOTAL] + 64'd1;
			if (dns) begin
				cnt_q[CNT_DNS] <= cnt_q[CNT_DNS] + 64'd1;
				case (vd)
					VERDICT_DROP: cnt_q[CNT_BLOCK] <= cnt_q[CNT_BLOCK] + 64'd1;
					VERDICT_REDIRECT: cnt_q[CNT_REDIR] <= cnt_q[CNT_REDIR] + 64'd1;
					default: cnt_q[CNT_PASS] <= cnt_q[CNT_PASS] + 64'd1;
				endcase
			end
		end
	end

	// Result FIFO; a counter read result never arrives in the same cycle as a verdict.
	localparam int RW = 1 + 2 + 6 + 1 + 64;
	logic [RW-1:0] fifo_q [FDEPTH];
	logic [FAW-1:0] wp_q, rp_q;
	logic [FAW:0] cnt_f_q;
	logic [FAW:0] inflight;
	logic push, pop;
	logic [RW-1:0] wdata;

	assign push = ch_valid || rd_v_s[LAT];
	always_comb begin
		if (ch_valid) begin
			wdata = {1'b0, vd, (vd == VERDICT_REDIRECT) ? ch_hdr.queue : 6'd0, dns, 64'd0};
		end else begin
			wdata = {1'b1, 2'd0, 6'd0, 1'b0, cnt_q[rd_sel_s[LAT]]};
		end
	end
	assign out_valid = cnt_f_q != '0;
	assign pop = out_valid && !out_stall;
	assign {result_kind, verdict, out_queue, is_dns, counter_value} = fifo_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wp_q] <= wdata;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_f_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_f_q <= cnt_f_q + (FAW+1)'(push) - (FAW+1)'(pop);
		end
	end

	// Verdicts still in the chain, one bit per stage.
	logic [LAT-1:0] chain_v_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_v_q <= '0;
		end else begin
			chain_v_q <= {chain_v_q[LAT-2:0], hdr_valid};
		end
	end

	// Stall when results in flight might overflow the FIFO.
	always_comb begin
		inflight = '0;
		for (int i = 0; i < LAT; i++) begin
			inflight = inflight + (FAW+1)'(rd_v_s[i+1] | chain_v_q[i]);
		end
	end
	assign in_stall = (cnt_f_q + inflight) >= (FAW+1)'(FDEPTH - 1);

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> cnt_f_q != (FAW+1)'(FDEPTH) || pop)
		else $error("result FIFO overflow");
	a_single_push: assert property (@(posedge clk) disable iff (!arst_n)
		!(ch_valid && rd_v_s[LAT]))
		else $error("verdict and counter read collide");
	a_chain_lat: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_valid |-> ##8 ch_valid)
		else $error("chain latency mismatch");
`endif

endmodule
`default_nettype wire
